@@ rtl/bsc_pkg.sv @@
package bsc_pkg;

	localparam int RAW_W    = 20;
	localparam int TEMP_W   = 16;
	localparam int PRESS_W  = 32;
	localparam int CFG_W    = 64;
	localparam int CFG_IDX_W = 2;
	localparam int FINE_W   = 28;
	localparam int V1_W     = 29;
	localparam int DEN_W    = 31;
	localparam int DIV_W    = 64;
	localparam int REM_W    = DEN_W;

	localparam logic signed [FINE_W-1:0] FINE_OFFSET = FINE_W'(128000);
	localparam logic [RAW_W:0]           PRESS_BASE  = (RAW_W+1)'(1048576);
	localparam logic signed [63:0]       V1_BIAS     = 64'sh0000_8000_0000_0000;
	localparam logic signed [63:0]       NUM_SCALE   = 64'sd3125;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMP_CALIB    = 2'd0,
		REG_PRESS_CALIB_A = 2'd1,
		REG_PRESS_CALIB_B = 2'd2,
		REG_PRESS_CALIB_C = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic        [15:0] t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic        [15:0] p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
	} calib_t;

	// data that rides alongside the division
	typedef struct packed {
		logic signed [TEMP_W-1:0] temp_centi;
		logic                     neg;
		logic                     zero;
	} side_t;

endpackage

@@ rtl/bsc_temp.sv @@
module bsc_temp (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    ce,
	input  bsc_pkg::calib_t                         calib,
	input  logic                                    in_valid,
	input  logic [bsc_pkg::RAW_W-1:0]               raw_temperature,
	input  logic [bsc_pkg::RAW_W-1:0]               raw_pressure,
	output logic                                    out_valid,
	output logic signed [bsc_pkg::TEMP_W-1:0]       temp_centi,
	output logic signed [bsc_pkg::V1_W-1:0]         v1,
	output logic [bsc_pkg::RAW_W-1:0]               adc_p
);

	logic                             vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [18:0]               ta_s1;
	logic signed [17:0]               td_s1;
	logic signed [34:0]               tam_s2;
	logic signed [35:0]               dd_s2;
	logic signed [23:0]               a_s3;
	logic signed [39:0]               bm_s3;
	logic signed [bsc_pkg::FINE_W-1:0] fine_s4;
	logic signed [30:0]               tcr;
	logic signed [22:0]               tc;
	logic signed [bsc_pkg::TEMP_W-1:0] tout_s5;
	logic signed [bsc_pkg::V1_W-1:0]   v1_s5;
	logic [bsc_pkg::RAW_W-1:0]         adcp_s1, adcp_s2, adcp_s3, adcp_s4, adcp_s5;

	assign tcr = 31'(fine_s4) * 31'sd5 + 31'sd128;
	assign tc  = $signed(tcr[30:8]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (ce) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			ta_s1   <= $signed({2'b00, raw_temperature[19:3]}) - $signed({2'b00, calib.t1, 1'b0});
			td_s1   <= $signed({2'b00, raw_temperature[19:4]}) - $signed({2'b00, calib.t1});
			adcp_s1 <= raw_pressure;

			tam_s2  <= 35'(ta_s1) * 35'(calib.t2);
			dd_s2   <= 36'(td_s1) * 36'(td_s1);
			adcp_s2 <= adcp_s1;

			a_s3    <= $signed(tam_s2[34:11]);
			bm_s3   <= 40'($signed(dd_s2[35:12])) * 40'(calib.t3);
			adcp_s3 <= adcp_s2;

			fine_s4 <= bsc_pkg::FINE_W'(a_s3) + bsc_pkg::FINE_W'($signed(bm_s3[39:14]));
			adcp_s4 <= adcp_s3;

			// clamp to the 16-bit output range
			if (tc < -23'sd32768)
				tout_s5 <= -16'sd32768;
			else if (tc > 23'sd32767)
				tout_s5 <= 16'sd32767;
			else
				tout_s5 <= $signed(tc[15:0]);
			v1_s5   <= bsc_pkg::V1_W'(fine_s4) - bsc_pkg::V1_W'(bsc_pkg::FINE_OFFSET);
			adcp_s5 <= adcp_s4;
		end
	end

	assign out_valid  = vld_s5;
	assign temp_centi = tout_s5;
	assign v1         = v1_s5;
	assign adc_p      = adcp_s5;

endmodule

@@ rtl/bsc_press_pre.sv @@
module bsc_press_pre (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                ce,
	input  bsc_pkg::calib_t                     calib,
	input  logic                                in_valid,
	input  logic signed [bsc_pkg::TEMP_W-1:0]   temp_centi,
	input  logic signed [bsc_pkg::V1_W-1:0]     v1,
	input  logic [bsc_pkg::RAW_W-1:0]           adc_p,
	output logic                                out_valid,
	output logic [bsc_pkg::DIV_W-1:0]           num_abs,
	output logic [bsc_pkg::DEN_W-1:0]           den_abs,
	output bsc_pkg::side_t                      side
);

	logic                              vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic signed [57:0]                v1sq_s1;
	logic signed [44:0]                v1p5_s1, v1p2_s1;
	logic signed [63:0]                v2a_s2, v1a_s2;
	logic signed [44:0]                v1p5_s2, v1p2_s2;
	logic signed [63:0]                v2_s3, v1b_s3;
	logic [bsc_pkg::RAW_W:0]           pm_s3;
	logic signed [63:0]                v1c_s4, nd_s4;
	logic signed [bsc_pkg::DEN_W-1:0]  den_s5;
	logic signed [63:0]                num_s5;
	logic [bsc_pkg::DIV_W-1:0]         an_s6;
	logic [bsc_pkg::DEN_W-1:0]         ad_s6;
	bsc_pkg::side_t                    side_s6;
	logic signed [bsc_pkg::TEMP_W-1:0] tc_s1, tc_s2, tc_s3, tc_s4, tc_s5;
	logic [bsc_pkg::RAW_W-1:0]         adcp_s1, adcp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (ce) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			v1sq_s1 <= 58'(v1) * 58'(v1);
			v1p5_s1 <= 45'(v1) * 45'(calib.p5);
			v1p2_s1 <= 45'(v1) * 45'(calib.p2);
			tc_s1   <= temp_centi;
			adcp_s1 <= adc_p;

			// products wrap at 64 bits
			v2a_s2  <= 64'(v1sq_s1) * 64'(calib.p6);
			v1a_s2  <= 64'(v1sq_s1) * 64'(calib.p3);
			v1p5_s2 <= v1p5_s1;
			v1p2_s2 <= v1p2_s1;
			tc_s2   <= tc_s1;
			adcp_s2 <= adcp_s1;

			v2_s3   <= v2a_s2 + (64'(v1p5_s2) <<< 17) + (64'(calib.p4) <<< 35);
			v1b_s3  <= (v1a_s2 >>> 8) + (64'(v1p2_s2) <<< 12);
			pm_s3   <= bsc_pkg::PRESS_BASE - {1'b0, adcp_s2};
			tc_s3   <= tc_s2;

			v1c_s4  <= (bsc_pkg::V1_BIAS + v1b_s3) * 64'($signed({1'b0, calib.p1}));
			nd_s4   <= $signed({12'd0, pm_s3, 31'd0}) - v2_s3;
			tc_s4   <= tc_s3;

			den_s5  <= $signed(v1c_s4[63:33]);
			num_s5  <= nd_s4 * bsc_pkg::NUM_SCALE;
			tc_s5   <= tc_s4;

			// split into magnitudes and a result sign for the divider
			an_s6   <= num_s5[63] ? 64'(-num_s5) : 64'(num_s5);
			ad_s6   <= den_s5[bsc_pkg::DEN_W-1] ? bsc_pkg::DEN_W'(-den_s5)
			                                    : bsc_pkg::DEN_W'(den_s5);
			side_s6.temp_centi <= tc_s5;
			side_s6.neg        <= num_s5[63] ^ den_s5[bsc_pkg::DEN_W-1];
			side_s6.zero       <= (den_s5 == '0);
		end
	end

	assign out_valid = vld_s6;
	assign num_abs   = an_s6;
	assign den_abs   = ad_s6;
	assign side      = side_s6;

endmodule

@@ rtl/bsc_div.sv @@
module bsc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          ce,
	input  logic                          in_valid,
	input  logic [bsc_pkg::DIV_W-1:0]     num_abs,
	input  logic [bsc_pkg::DEN_W-1:0]     den_abs,
	input  bsc_pkg::side_t                side_in,
	output logic                          out_valid,
	output logic [bsc_pkg::DIV_W-1:0]     quotient,
	output bsc_pkg::side_t                side_out
);

	// one quotient bit per stage, restoring
	logic                          vld_s  [bsc_pkg::DIV_W+1];
	logic [bsc_pkg::DIV_W-1:0]     nq_s   [bsc_pkg::DIV_W+1];
	logic [bsc_pkg::REM_W-1:0]     rem_s  [bsc_pkg::DIV_W+1];
	logic [bsc_pkg::DEN_W-1:0]     den_s  [bsc_pkg::DIV_W+1];
	bsc_pkg::side_t                side_s [bsc_pkg::DIV_W+1];

	assign vld_s[0]  = in_valid;
	assign nq_s[0]   = num_abs;
	assign rem_s[0]  = '0;
	assign den_s[0]  = den_abs;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < bsc_pkg::DIV_W; k++) begin : g_stage
		logic [bsc_pkg::REM_W:0] trial;
		logic [bsc_pkg::REM_W:0] diff;
		logic                    ge;

		assign trial = {rem_s[k], nq_s[k][bsc_pkg::DIV_W-1]};
		assign diff  = trial - {1'b0, den_s[k]};
		assign ge    = (trial >= {1'b0, den_s[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (ce)
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				rem_s[k+1]  <= ge ? diff[bsc_pkg::REM_W-1:0] : trial[bsc_pkg::REM_W-1:0];
				nq_s[k+1]   <= {nq_s[k][bsc_pkg::DIV_W-2:0], ge};
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[bsc_pkg::DIV_W];
	assign quotient  = nq_s[bsc_pkg::DIV_W];
	assign side_out  = side_s[bsc_pkg::DIV_W];

endmodule

@@ rtl/bsc_press_post.sv @@
module bsc_press_post (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                ce,
	input  bsc_pkg::calib_t                     calib,
	input  logic                                in_valid,
	input  logic [bsc_pkg::DIV_W-1:0]           quotient,
	input  bsc_pkg::side_t                      side,
	output logic                                out_valid,
	output logic signed [bsc_pkg::TEMP_W-1:0]   temp_centi,
	output logic [bsc_pkg::PRESS_W-1:0]         pressure_q24_8,
	output logic                                pressure_valid
);

	logic                              vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic signed [63:0]                p_s1, p_s2, p_s3, p_s4;
	logic signed [63:0]                x;
	logic [63:0]                       sql_s2;
	logic [31:0]                       cross_s2;
	logic signed [63:0]                w2m_s2;
	logic signed [63:0]                xx_s3, w2_s3, w2_s4;
	logic signed [63:0]                w1m_s4;
	logic signed [63:0]                t_s5;
	logic signed [63:0]                r;
	logic [bsc_pkg::PRESS_W-1:0]       pout_s6;
	logic                              pv_s6;
	logic signed [bsc_pkg::TEMP_W-1:0] tc_s1, tc_s2, tc_s3, tc_s4, tc_s5, tc_s6;
	logic                              z_s1, z_s2, z_s3, z_s4, z_s5;

	assign x = p_s1 >>> 13;
	assign r = (t_s5 >>> 8) + (64'(calib.p7) <<< 4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (ce) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			p_s1     <= side.neg ? $signed(-quotient) : $signed(quotient);
			tc_s1    <= side.temp_centi;
			z_s1     <= side.zero;

			// square modulo 2^64 from 32-bit halves
			sql_s2   <= 64'(x[31:0]) * 64'(x[31:0]);
			cross_s2 <= x[31:0] * x[63:32];
			w2m_s2   <= p_s1 * 64'(calib.p8);
			p_s2     <= p_s1;
			tc_s2    <= tc_s1;
			z_s2     <= z_s1;

			xx_s3    <= $signed(sql_s2 + {cross_s2[30:0], 33'd0});
			w2_s3    <= w2m_s2 >>> 19;
			p_s3     <= p_s2;
			tc_s3    <= tc_s2;
			z_s3     <= z_s2;

			w1m_s4   <= xx_s3 * 64'(calib.p9);
			w2_s4    <= w2_s3;
			p_s4     <= p_s3;
			tc_s4    <= tc_s3;
			z_s4     <= z_s3;

			t_s5     <= p_s4 + (w1m_s4 >>> 25) + w2_s4;
			tc_s5    <= tc_s4;
			z_s5     <= z_s4;

			tc_s6    <= tc_s5;
			pv_s6    <= !z_s5;
			if (z_s5 || r[63])
				pout_s6 <= '0;
			else if (r[62:32] != '0)
				pout_s6 <= '1;
			else
				pout_s6 <= r[31:0];
		end
	end

	assign out_valid      = vld_s6;
	assign temp_centi     = tc_s6;
	assign pressure_q24_8 = pout_s6;
	assign pressure_valid = pv_s6;

endmodule

@@ rtl/barometric_sensor_compensation.sv @@
// Barometric sensor compensation. Each input beat carries one raw 20-bit temperature and one
// raw 20-bit pressure reading; each output beat carries the compensated temperature in
// hundredths of a degree (signed, clamped to 16 bits), the pressure in pascals as unsigned
// Q24.8 (clamped to 32 bits) and, in tuser, a flag that is 0 when the pressure divisor came
// out zero (pressure then reads 0). The datapath is a fully pipelined chain: 5 stages of
// temperature math, 6 stages that build the pressure numerator and divisor, a 64-stage
// restoring divider that resolves one quotient bit per stage, and 6 stages of final
// correction and clamping. One beat enters per clock whenever the chain advances. The whole chain
// advances together, so it holds only while the output register is full and the sink is not
// ready. Write the four calibration registers only while no beat is in flight.
module barometric_sensor_compensation (
	input  logic                          clk,
	input  logic                          arst_n,

	// calibration writes; the port is always ready
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bsc_pkg::CFG_W-1:0]     cfg_data,

	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [39:0]                   s_axis_tdata,  // [19:0] raw_temperature, [39:20] raw_pressure

	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [47:0]                   m_axis_tdata,  // [15:0] temperature_centi, [47:16] pressure_q24_8
	output logic                          m_axis_tuser   // [0] pressure_valid
);

	logic [47:0]            temp_calib_q;
	logic [63:0]            press_calib_a_q;
	logic [63:0]            press_calib_b_q;
	logic [15:0]            press_calib_c_q;
	bsc_pkg::calib_t        calib;

	logic                   ce;

	logic                                 t_valid;
	logic signed [bsc_pkg::TEMP_W-1:0]    t_temp;
	logic signed [bsc_pkg::V1_W-1:0]      t_v1;
	logic [bsc_pkg::RAW_W-1:0]            t_adcp;

	logic                                 pre_valid;
	logic [bsc_pkg::DIV_W-1:0]            pre_num;
	logic [bsc_pkg::DEN_W-1:0]            pre_den;
	bsc_pkg::side_t                       pre_side;

	logic                                 div_valid;
	logic [bsc_pkg::DIV_W-1:0]            div_q;
	bsc_pkg::side_t                       div_side;

	logic signed [bsc_pkg::TEMP_W-1:0]    out_temp;
	logic [bsc_pkg::PRESS_W-1:0]          out_press;
	logic                                 out_pvalid;

	// calibration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_calib_q    <= '0;
			press_calib_a_q <= '0;
			press_calib_b_q <= '0;
			press_calib_c_q <= '0;
		end else if (cfg_valid) begin
			case (bsc_pkg::cfg_reg_t'(cfg_index))
				bsc_pkg::REG_TEMP_CALIB:    temp_calib_q    <= cfg_data[47:0];
				bsc_pkg::REG_PRESS_CALIB_A: press_calib_a_q <= cfg_data;
				bsc_pkg::REG_PRESS_CALIB_B: press_calib_b_q <= cfg_data;
				bsc_pkg::REG_PRESS_CALIB_C: press_calib_c_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// unpack the calibration words
	assign calib.t1 = temp_calib_q[15:0];
	assign calib.t2 = $signed(temp_calib_q[31:16]);
	assign calib.t3 = $signed(temp_calib_q[47:32]);
	assign calib.p1 = press_calib_a_q[15:0];
	assign calib.p2 = $signed(press_calib_a_q[31:16]);
	assign calib.p3 = $signed(press_calib_a_q[47:32]);
	assign calib.p4 = $signed(press_calib_a_q[63:48]);
	assign calib.p5 = $signed(press_calib_b_q[15:0]);
	assign calib.p6 = $signed(press_calib_b_q[31:16]);
	assign calib.p7 = $signed(press_calib_b_q[47:32]);
	assign calib.p8 = $signed(press_calib_b_q[63:48]);
	assign calib.p9 = $signed(press_calib_c_q);

	// advance every stage unless a finished beat is held at the output
	assign ce            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = ce;

	bsc_temp u_temp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ce              (ce),
		.calib           (calib),
		.in_valid        (s_axis_tvalid),
		.raw_temperature (s_axis_tdata[19:0]),
		.raw_pressure    (s_axis_tdata[39:20]),
		.out_valid       (t_valid),
		.temp_centi      (t_temp),
		.v1              (t_v1),
		.adc_p           (t_adcp)
	);

	bsc_press_pre u_pre (
		.clk        (clk),
		.arst_n     (arst_n),
		.ce         (ce),
		.calib      (calib),
		.in_valid   (t_valid),
		.temp_centi (t_temp),
		.v1         (t_v1),
		.adc_p      (t_adcp),
		.out_valid  (pre_valid),
		.num_abs    (pre_num),
		.den_abs    (pre_den),
		.side       (pre_side)
	);

	bsc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (pre_valid),
		.num_abs   (pre_num),
		.den_abs   (pre_den),
		.side_in   (pre_side),
		.out_valid (div_valid),
		.quotient  (div_q),
		.side_out  (div_side)
	);

	// last stage of this unit is the output register
	bsc_press_post u_post (
		.clk            (clk),
		.arst_n         (arst_n),
		.ce             (ce),
		.calib          (calib),
		.in_valid       (div_valid),
		.quotient       (div_q),
		.side           (div_side),
		.out_valid      (m_axis_tvalid),
		.temp_centi     (out_temp),
		.pressure_q24_8 (out_press),
		.pressure_valid (out_pvalid)
	);

	assign m_axis_tdata = {out_press, out_temp};
	assign m_axis_tuser = out_pvalid;

endmodule

@@ tb/barometric_sensor_compensation_test.sv @@
module barometric_sensor_compensation_test;

	typedef struct {
		logic signed [15:0] temp_centi;
		logic        [31:0] press;
		logic               press_ok;
	} reading_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bsc_pkg::CFG_W-1:0] cfg_data;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [39:0] s_axis_tdata;	// [19:0] raw_temperature, [39:20] raw_pressure
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [47:0] m_axis_tdata;	// [15:0] temperature_centi, [47:16] pressure_q24_8
	logic m_axis_tuser;	// [0] pressure_valid

	barometric_sensor_compensation dut (.*);

	// calibration copy held by the predictor
	logic [47:0] cal_temp;
	logic [63:0] cal_pa, cal_pb;
	logic [15:0] cal_p9;

	logic [39:0] raw_q[$];	// beats waiting to be offered
	reading_t expected_q[$];	// compensated readings awaiting the output
	int errors;
	int hold_off;	// cycles of forced sink stall still to run
	int src_gap, snk_gap;

	function automatic logic signed [63:0] s16(logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	// wrap-around 64-bit signed division, truncating toward zero
	function automatic logic signed [63:0] div_trunc(logic signed [63:0] n, logic signed [63:0] d);
		logic [63:0] an, ad, q;
		an = n[63] ? -n : n;
		ad = d[63] ? -d : d;
		q = an / ad;
		return (n[63] != d[63]) ? -q : q;
	endfunction

	function automatic reading_t compensate(logic [19:0] adc_t, logic [19:0] adc_p);
		logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic signed [63:0] a, d, b, fine, tc, v1, v2, p, w1, w2;
		reading_t r;
		t1 = {48'd0, cal_temp[15:0]};
		t2 = s16(cal_temp[31:16]);
		t3 = s16(cal_temp[47:32]);
		p1 = {48'd0, cal_pa[15:0]};
		p2 = s16(cal_pa[31:16]);
		p3 = s16(cal_pa[47:32]);
		p4 = s16(cal_pa[63:48]);
		p5 = s16(cal_pb[15:0]);
		p6 = s16(cal_pb[31:16]);
		p7 = s16(cal_pb[47:32]);
		p8 = s16(cal_pb[63:48]);
		p9 = s16(cal_p9);
		a = (($signed(64'(adc_t >> 3)) - (t1 <<< 1)) * t2) >>> 11;
		d = 64'(adc_t >> 4) - t1;
		b = (((d * d) >>> 12) * t3) >>> 14;
		fine = a + b;
		tc = (fine * 5 + 128) >>> 8;
		if (tc < -32768) r.temp_centi = -16'sd32768;
		else if (tc > 32767) r.temp_centi = 16'sd32767;
		else r.temp_centi = tc[15:0];
		v1 = fine - 128000;
		v2 = v1 * v1 * p6 + ((v1 * p5) <<< 17) + (p4 <<< 35);
		v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
		v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
		r.press = '0;
		r.press_ok = 1'b0;
		if (v1 != 0) begin
			p = 64'sd1048576 - 64'(adc_p);
			p = div_trunc(((p <<< 31) - v2) * 3125, v1);
			w1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
			w2 = (p8 * p) >>> 19;
			p = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
			if (p < 0) r.press = '0;
			else if (p > 64'sh0FFFFFFFF) r.press = '1;
			else r.press = p[31:0];
			r.press_ok = 1'b1;
		end
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("barometric_sensor_compensation regression: fail");
		$finish;
	end

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 60) return 0;
		if (k < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// driver: offer queued beats, predict on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			src_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_q.push_back(compensate(s_axis_tdata[19:0], s_axis_tdata[39:20]));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap > 0 || raw_q.size() == 0) begin
					s_axis_tvalid <= 1'b0;
					if (src_gap > 0) src_gap <= src_gap - 1;
				end else begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= raw_q.pop_front();
					src_gap <= pick_gap();
				end
			end
		end
	end

	// monitor: sink readiness and compare each output beat with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		reading_t e;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			snk_gap <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_q.size() == 0) begin
					$error("output beat with no reading pending");
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (m_axis_tdata[15:0] !== e.temp_centi) begin
						$error("temperature_centi exp %0d got %0d", e.temp_centi,
							$signed(m_axis_tdata[15:0]));
						errors++;
					end
					if (m_axis_tdata[47:16] !== e.press) begin
						$error("pressure_q24_8 exp %0h got %0h", e.press, m_axis_tdata[47:16]);
						errors++;
					end
					if (m_axis_tuser !== e.press_ok) begin
						$error("pressure_valid exp %0b got %0b", e.press_ok, m_axis_tuser);
						errors++;
					end
				end
			end
			if (hold_off > 0) begin
				m_axis_tready <= 1'b0;
				hold_off <= hold_off - 1;
			end else if (snk_gap > 0) begin
				m_axis_tready <= 1'b0;
				snk_gap <= snk_gap - 1;
			end else begin
				m_axis_tready <= 1'b1;
				snk_gap <= pick_gap();
			end
		end
	end

	task automatic cfg_write(bsc_pkg::cfg_reg_t idx, logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			bsc_pkg::REG_TEMP_CALIB: cal_temp = val[47:0];
			bsc_pkg::REG_PRESS_CALIB_A: cal_pa = val;
			bsc_pkg::REG_PRESS_CALIB_B: cal_pb = val;
			bsc_pkg::REG_PRESS_CALIB_C: cal_p9 = val[15:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (raw_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// typical sensor calibration, jittered; sometimes fully random words
	task automatic load_calib(int style);
		logic [63:0] ta, pa, pb, pc;
		if (style == 0) begin
			ta = 64'({16'($urandom), 16'($urandom), 16'($urandom)});
			pa = {$urandom, $urandom};
			pb = {$urandom, $urandom};
			pc = 64'($urandom);
		end else begin
			ta = 64'({16'(-1000 + $urandom_range(0, 2000)),
				16'(26000 + $urandom_range(0, 2000)),
				16'(27000 + $urandom_range(0, 2000))});
			pa = {16'(2000 + $urandom_range(0, 3000)), 16'(24 + $urandom_range(0, 8000)),
				16'(-10700 + $urandom_range(0, 1000)), 16'(36000 + $urandom_range(0, 3000))};
			pb = {16'(-14600 + $urandom_range(0, 1000)), 16'(15000 + $urandom_range(0, 1000)),
				16'(-7 - $urandom_range(0, 20)), 16'($urandom_range(0, 300))};
			pc = 64'(5000 + $urandom_range(0, 2000));
		end
		cfg_write(bsc_pkg::REG_TEMP_CALIB, ta);
		cfg_write(bsc_pkg::REG_PRESS_CALIB_A, pa);
		cfg_write(bsc_pkg::REG_PRESS_CALIB_B, pb);
		cfg_write(bsc_pkg::REG_PRESS_CALIB_C, pc);
	endtask

	function automatic logic [19:0] raw_val();
		case ($urandom_range(0, 5))
			0: return 20'h00000;
			1: return 20'hFFFFF;
			2: return 20'($urandom_range(400000, 600000));
			default: return 20'($urandom);
		endcase
	endfunction

	initial begin
		errors = 0;
		hold_off = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		cal_temp = '0;
		cal_pa = '0;
		cal_pb = '0;
		cal_p9 = '0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;

		// reset calibration: divisor is zero, pressure reads 0 and not valid
		raw_q.push_back({20'h00000, 20'h00000});
		raw_q.push_back({20'hFFFFF, 20'hFFFFF});
		drain();

		// extremes of every calibration word
		cfg_write(bsc_pkg::REG_TEMP_CALIB, 64'({16'h8000, 16'h7FFF, 16'hFFFF}));
		cfg_write(bsc_pkg::REG_PRESS_CALIB_A, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF});
		cfg_write(bsc_pkg::REG_PRESS_CALIB_B, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
		cfg_write(bsc_pkg::REG_PRESS_CALIB_C, 64'h8000);
		raw_q.push_back({20'h00000, 20'h00000});
		raw_q.push_back({20'hFFFFF, 20'h00000});
		raw_q.push_back({20'h00000, 20'hFFFFF});
		raw_q.push_back({20'hFFFFF, 20'hFFFFF});
		raw_q.push_back({20'h55555, 20'hAAAAA});
		raw_q.push_back({20'hAAAAA, 20'h55555});
		drain();
		cfg_write(bsc_pkg::REG_TEMP_CALIB, 64'({16'h7FFF, 16'h8000, 16'h0000}));
		cfg_write(bsc_pkg::REG_PRESS_CALIB_A, {16'h8000, 16'h7FFF, 16'h8000, 16'h0001});
		cfg_write(bsc_pkg::REG_PRESS_CALIB_B, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
		cfg_write(bsc_pkg::REG_PRESS_CALIB_C, 64'h7FFF);
		for (int i = 0; i < 8; i++) raw_q.push_back({raw_val(), raw_val()});
		drain();

		// random phases; one stalls the sink long while the source keeps offering
		for (int ph = 0; ph < 12; ph++) begin
			load_calib(ph % 3 == 0 ? 0 : 1);
			for (int i = 0; i < 155; i++) raw_q.push_back({raw_val(), raw_val()});
			if (ph == 2) hold_off = 300;
			drain();
		end

		if (errors == 0)
			$display("barometric_sensor_compensation regression: pass");
		else
			$display("barometric_sensor_compensation regression: fail");
		$finish;
	end
endmodule

@@ sim.f @@
rtl/bsc_pkg.sv
rtl/bsc_temp.sv
rtl/bsc_press_pre.sv
rtl/bsc_div.sv
rtl/bsc_press_post.sv
rtl/barometric_sensor_compensation.sv
tb/barometric_sensor_compensation_test.sv
